// ===== design/banded_matrix_store_defines.svh =====
// ----------------------------------------------------------------------------
// Banded matrix store: assertion macros
// Shared property templates, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BANDED_MATRIX_STORE_DEFINES_SVH
`define BANDED_MATRIX_STORE_DEFINES_SVH

// same-cycle implication
`define BMS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_pkg
// Types, widths and constants shared by the banded matrix store.
// ----------------------------------------------------------------------------
package bms_pkg;

	localparam int DEF_MAX_SIZE    = 256;
	localparam int DEF_MAX_BAND    = 31;
	localparam int DEF_STORE_DEPTH = 16384;

	localparam int SIZE_W     = 9;
	localparam int BAND_W     = 5;
	localparam int COORD_W    = 8;
	localparam int VALUE_W    = 32;
	localparam int OPCODE_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int MUL_W      = 9;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int ACC_W      = 21;

	localparam logic [SIZE_W-1:0]  SIZE_RESET = 9'd256;
	localparam logic [BAND_W-1:0]  BAND_RESET = 5'd8;
	localparam logic [VALUE_W-1:0] Q_MIN      = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] Q_MAX      = 32'h7FFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HALF_WIDTH = 1'd1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_SET   = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLIP,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_SUM,
		ST_ADDR,
		ST_READ,
		ST_EXEC
	} state_t;

	typedef enum logic [1:0] {
		MUL_HEAD,
		MUL_SPAN,
		MUL_TAIL
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD_HALF,
		ACC_ADD,
		ACC_SUB_HALF
	} acc_op_t;

	typedef struct packed {
		logic     req_ready;
		logic     clip;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     addr_en;
		logic     mem_rd;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic req_valid;
		logic ok;
		logic out_busy;
	} sts_t;

endpackage

// ===== design/bms_if.sv =====
// ----------------------------------------------------------------------------
// bms_req_if / bms_rsp_if
// Valid/ready channels for requests and results of the banded matrix store.
// ----------------------------------------------------------------------------
interface bms_req_if;
	import bms_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [OPCODE_W-1:0]        opcode;
	logic [COORD_W-1:0]         row;
	logic [COORD_W-1:0]         col;
	logic signed [VALUE_W-1:0]  operand;

	modport source (output valid, output opcode, output row, output col, output operand,
		input ready);
	modport sink (input valid, input opcode, input row, input col, input operand,
		output ready);
endinterface

interface bms_rsp_if;
	import bms_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       status;
	logic signed [VALUE_W-1:0]  read_value;

	modport source (output valid, output status, output read_value, input ready);
	modport sink (input valid, input status, input read_value, output ready);
endinterface

// ===== design/bms_ctrl.sv =====
// ----------------------------------------------------------------------------
// bms_ctrl
// Sequencer: walks one request through clipping, the three multiplier
// passes, address formation, the store read and the final update.
// ----------------------------------------------------------------------------
module bms_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  bms_pkg::sts_t sts,
	output bms_pkg::cmd_t cmd
);
	import bms_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '{
			req_ready: 1'b0,
			clip:      1'b0,
			mul_en:    1'b0,
			mul_sel:   MUL_HEAD,
			acc_op:    ACC_HOLD,
			addr_en:   1'b0,
			mem_rd:    1'b0,
			finish:    1'b0
		};
		case (state_q)
			ST_IDLE: begin
				cmd.req_ready = 1'b1;
				if (sts.req_valid) state_d = ST_CLIP;
			end
			ST_CLIP: begin
				cmd.clip = 1'b1;
				state_d = ST_MUL_A;
			end
			ST_MUL_A: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_HEAD;
				state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_SPAN;
				cmd.acc_op = ACC_LOAD_HALF;
				state_d = ST_MUL_C;
			end
			ST_MUL_C: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_TAIL;
				cmd.acc_op = ACC_ADD;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.acc_op = ACC_SUB_HALF;
				state_d = ST_ADDR;
			end
			ST_ADDR: begin
				cmd.addr_en = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.mem_rd = sts.ok;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// hold the finished word until the output register is free
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/bms_dp.sv =====
// ----------------------------------------------------------------------------
// bms_dp
// Datapath: configuration registers, request capture, packed address
// arithmetic on one shared multiplier, the cell store and the output register.
// ----------------------------------------------------------------------------
`include "banded_matrix_store_defines.svh"

module bms_dp #(
	parameter int MAX_SIZE    = bms_pkg::DEF_MAX_SIZE,
	parameter int MAX_BAND    = bms_pkg::DEF_MAX_BAND,
	parameter int STORE_DEPTH = bms_pkg::DEF_STORE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bms_pkg::CFG_DATA_W-1:0]     cfg_data,
	bms_req_if.sink                            req,
	bms_rsp_if.source                          rsp,
	input  bms_pkg::cmd_t                      cmd,
	output bms_pkg::sts_t                      sts
);
	import bms_pkg::*;

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [SIZE_W-1:0]  size_q;
	logic [BAND_W-1:0]  band_q;

	logic [OPCODE_W-1:0] op_q;
	logic [COORD_W-1:0]  row_q;
	logic [COORD_W-1:0]  col_q;
	logic [VALUE_W-1:0]  operand_q;

	logic [SIZE_W-1:0]  n_c;
	logic [BAND_W-1:0]  b_c;
	logic [SIZE_W-1:0]  nb_c;
	logic [COORD_W-1:0] dist_c;
	logic [COORD_W-1:0] m_c;

	logic               ok_q;
	logic [SIZE_W-1:0]  n_q;
	logic [BAND_W-1:0]  b_q;
	logic [COORD_W-1:0] m_q;
	logic [COORD_W-1:0] rm_q;
	logic [COORD_W-1:0] t_q;
	logic [COORD_W-1:0] lo_q;

	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   addr_sum;
	logic [AW-1:0]      addr_q;

	logic [VALUE_W-1:0] mem [STORE_DEPTH];
	logic [VALUE_W-1:0] rd_q;
	logic               mem_we;
	logic [VALUE_W-1:0] wdata;
	logic [VALUE_W:0]   sum_c;

	logic               out_valid_q;
	logic               status_q;
	logic [VALUE_W-1:0] value_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			band_q <= BAND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MATRIX_SIZE:     size_q <= cfg_data[SIZE_W-1:0];
				REG_BAND_HALF_WIDTH: band_q <= cfg_data[BAND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign req.ready = cmd.req_ready;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q      <= req.opcode;
			row_q     <= req.row;
			col_q     <= req.col;
			operand_q <= req.operand;
		end
	end

	// clipping: n, band, in-band check and the row counts for the closed-form sum
	assign n_c    = (int'(size_q) > MAX_SIZE) ? SIZE_W'(MAX_SIZE) : size_q;
	assign b_c    = (int'(band_q) > MAX_BAND) ? BAND_W'(MAX_BAND) : band_q;
	assign nb_c   = (n_c > SIZE_W'(b_c)) ? n_c - SIZE_W'(b_c) : '0;
	assign dist_c = (row_q > col_q) ? row_q - col_q : col_q - row_q;
	// m: earlier rows whose right edge is not cut by the matrix border
	assign m_c    = (SIZE_W'(row_q) < nb_c) ? row_q : nb_c[COORD_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.clip) begin
			n_q  <= n_c;
			b_q  <= b_c;
			m_q  <= m_c;
			rm_q <= row_q - m_c;
			t_q  <= (row_q > COORD_W'(b_c)) ? row_q - COORD_W'(b_c) - COORD_W'(1) : '0;
			lo_q <= (row_q > COORD_W'(b_c)) ? row_q - COORD_W'(b_c) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (cmd.clip) begin
			ok_q <= (SIZE_W'(row_q) < n_c) && (SIZE_W'(col_q) < n_c)
				&& (dist_c <= COORD_W'(b_c));
		end else if (cmd.addr_en) begin
			ok_q <= ok_q && (addr_sum < ACC_W'(STORE_DEPTH));
		end
	end

	// earlier rows: m(m+2b+1)/2 + (row-m)n - t(t+1)/2
	always_comb begin
		case (cmd.mul_sel)
			MUL_HEAD: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'(m_q) + MUL_W'({b_q, 1'b0}) + MUL_W'(1);
			end
			MUL_SPAN: begin
				mul_a = MUL_W'(rm_q);
				mul_b = MUL_W'(n_q);
			end
			MUL_TAIL: begin
				mul_a = MUL_W'(t_q);
				mul_b = MUL_W'(t_q) + MUL_W'(1);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_ff @(posedge clk) begin
		case (cmd.acc_op)
			ACC_LOAD_HALF: acc_q <= ACC_W'(prod_q[PROD_W-1:1]);
			ACC_ADD:       acc_q <= acc_q + ACC_W'(prod_q);
			ACC_SUB_HALF:  acc_q <= acc_q - ACC_W'(prod_q[PROD_W-1:1]);
			default: begin
			end
		endcase
	end

	assign addr_sum = acc_q + ACC_W'(col_q) - ACC_W'(lo_q);

	always_ff @(posedge clk) begin
		if (cmd.addr_en) addr_q <= addr_sum[AW-1:0];
	end

	// cell store
	assign sum_c  = {rd_q[VALUE_W-1], rd_q} + {operand_q[VALUE_W-1], operand_q};
	assign mem_we = cmd.finish && ok_q
		&& (op_t'(op_q) == OP_SET || op_t'(op_q) == OP_ADD);

	always_comb begin
		if (op_t'(op_q) == OP_SET) begin
			wdata = operand_q;
		end else if (sum_c[VALUE_W] != sum_c[VALUE_W-1]) begin
			wdata = sum_c[VALUE_W] ? Q_MIN : Q_MAX;
		end else begin
			wdata = sum_c[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr_q] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) rd_q <= mem[addr_q];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= !ok_q;
			if (!ok_q) begin
				value_q <= Q_MIN;
			end else begin
				case (op_t'(op_q))
					OP_SET:  value_q <= '0;
					OP_ADD:  value_q <= '0;
					default: value_q <= rd_q;
				endcase
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_value = value_q;

	assign sts.req_valid = req.valid;
	assign sts.ok        = ok_q;
	assign sts.out_busy  = out_valid_q && !rsp.ready;

	`BMS_ASSERT_IMPLIES(a_refused_word_min, out_valid_q && status_q, value_q == Q_MIN, "refused word without minimum value")
	`BMS_ASSERT_IMPLIES(a_write_only_ok, mem_we, ok_q && !sts.out_busy, "store written for a refused cell")
	`BMS_ASSERT_NEXT(a_finish_shows_word, cmd.finish, out_valid_q, "finished word not presented")

endmodule

// ===== design/banded_matrix_store.sv =====
// ----------------------------------------------------------------------------
// banded_matrix_store
// Compact store for the band |row - col| <= band of an n-by-n Q16.16 matrix.
//
// req carries one word per access: opcode (set, add, query), row, col and
// operand. rsp returns one word per request: status (1 = cell outside band,
// matrix or store, nothing changed) and read_value (cell on query, zero on
// set/add, most negative value when refused). cfg_we/cfg_index/cfg_data
// write matrix_size (index 0) and band_half_width (index 1); the user must
// do so only while idle; the block itself does not enforce it. req.ready is
// high only while idle, so no request is taken before the last is finished;
// the next can be taken while the result is on rsp. A request forms the
// packed address sum in three passes through one shared 9x9 multiplier and
// reads the store before the update. Add saturates to the Q16.16 range.
// Reset sets n = 256, band = 8 and empties the output register; the store
// contents are not cleared and a cell must be set before it is read.
// While rsp is stalled the finished word is held; a request taken meanwhile
// waits in the final step until the output register frees, with req.ready low.
// ----------------------------------------------------------------------------
module banded_matrix_store #(
	parameter int MAX_SIZE    = bms_pkg::DEF_MAX_SIZE,
	parameter int MAX_BAND    = bms_pkg::DEF_MAX_BAND,
	parameter int STORE_DEPTH = bms_pkg::DEF_STORE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bms_pkg::CFG_DATA_W-1:0] cfg_data,
	bms_req_if.sink                        req,
	bms_rsp_if.source                      rsp
);
	import bms_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	bms_dp #(
		.MAX_SIZE    (MAX_SIZE),
		.MAX_BAND    (MAX_BAND),
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
